// File: hw/rtl/bxf_pkg.sv
// Shared types, constants and helpers for the 3x3 RGBA box filter.
package bxf_pkg;

   localparam int CH_W       = 8;
   localparam int PIX_W      = 4 * CH_W;
   localparam int SUM_W      = 12;           // nine 8-bit samples
   localparam int DIV9_MULT  = 7282;         // ceil(2^16 / 9)
   localparam int DIV9_SHIFT = 16;
   localparam int PROD_W     = SUM_W + DIV9_SHIFT;

   localparam int IMG_W_W    = 12;
   localparam int IMG_H_W    = 13;
   localparam int CSR_DATA_W = 13;
   localparam int OUT_ROW_W  = 12;
   localparam int OUT_COL_W  = 11;

   localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 12'd640;
   localparam logic [IMG_H_W-1:0] HEIGHT_RESET = 13'd480;

   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_LEVEL_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } bxf_csr_type;

   // what the back end owes for one pixel word
   typedef struct packed {
      logic need_mean;
      logic need_border;
      logic frame_end;
   } bxf_tag_type;

   localparam int TAG_W = $bits(bxf_tag_type);

   // floor(s / 9) for s < 2296 via reciprocal multiply
   function automatic logic [CH_W-1:0] bxf_div9(input logic [SUM_W-1:0] s);
      logic [PROD_W-1:0] p;
      p = PROD_W'(s) * PROD_W'(DIV9_MULT);
      return p[DIV9_SHIFT +: CH_W];
   endfunction

endpackage

// File: hw/rtl/bxf_queue.sv
// Small register FIFO between the front and back ends.
module bxf_queue #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic                       out_valid,
   output logic [WIDTH-1:0]           out_data,
   output logic [$clog2(DEPTH+1)-1:0] level
);

   localparam int PW = $clog2(DEPTH);
   localparam int LW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [LW-1:0]    level_ff, level_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      level_in = level_ff + LW'(push_valid) - LW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (level_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign level     = level_ff;

endmodule

// File: hw/rtl/bxf_front.sv
// Front end: config registers, raster counters, line buffer memory, classification.
module bxf_front #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  bxf_pkg::bxf_csr_type                csr_index,
   input  logic [bxf_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [bxf_pkg::CH_W-1:0]            req_in_red,
   input  logic [bxf_pkg::CH_W-1:0]            req_in_green,
   input  logic [bxf_pkg::CH_W-1:0]            req_in_blue,
   input  logic [bxf_pkg::CH_W-1:0]            req_in_alpha,
   input  logic [bxf_pkg::QUEUE_LEVEL_W-1:0]   q_level,
   output logic                                push_valid,
   output logic [bxf_pkg::TAG_W + $clog2(MAX_HEIGHT) + $clog2(MAX_WIDTH)
                 + 3*bxf_pkg::PIX_W - 1:0]     push_data
);

   import bxf_pkg::*;

   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int CRW = QUEUE_LEVEL_W + 1;

   logic [IMG_W_W-1:0] width_reg_ff;
   logic [IMG_H_W-1:0] height_reg_ff;

   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [WW-1:0] act_w_ff;
   logic [HW-1:0] act_h_ff;

   logic [WW-1:0] clamp_w, cur_w;
   logic [HW-1:0] clamp_h, cur_h;
   logic          frame_start, col_last, row_last, accept;
   bxf_tag_type   tag;

   // line memory word: {row r-2, row r-1}
   logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
   logic [2*PIX_W-1:0] rd_data_ff;

   logic               s1_valid_ff;
   bxf_tag_type        s1_tag_ff;
   logic [RW-1:0]      s1_row_ff;
   logic [CW-1:0]      s1_col_ff;
   logic [PIX_W-1:0]   s1_pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_reg_ff  <= WIDTH_RESET;
         height_reg_ff <= HEIGHT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_reg_ff  <= csr_wdata[IMG_W_W-1:0];
            CSR_IMAGE_HEIGHT: height_reg_ff <= csr_wdata[IMG_H_W-1:0];
            default:          width_reg_ff  <= width_reg_ff;
         endcase
      end
   end

   // zero acts as one, oversize saturates
   always_comb begin
      if (width_reg_ff == '0) begin
         clamp_w = WW'(1);
      end else if (32'(width_reg_ff) > 32'(MAX_WIDTH)) begin
         clamp_w = WW'(MAX_WIDTH);
      end else begin
         clamp_w = WW'(width_reg_ff);
      end
      if (height_reg_ff == '0) begin
         clamp_h = HW'(1);
      end else if (32'(height_reg_ff) > 32'(MAX_HEIGHT)) begin
         clamp_h = HW'(MAX_HEIGHT);
      end else begin
         clamp_h = HW'(height_reg_ff);
      end
   end

   assign frame_start = (row_ff == '0) && (col_ff == '0);
   assign cur_w       = frame_start ? clamp_w : act_w_ff;
   assign cur_h       = frame_start ? clamp_h : act_h_ff;
   assign col_last    = (WW'(col_ff) + WW'(1) == cur_w);
   assign row_last    = (HW'(row_ff) + HW'(1) == cur_h);

   always_comb begin
      tag.need_mean   = (row_ff >= RW'(2)) && (col_ff >= CW'(2));
      tag.need_border = (row_ff == '0) || (col_ff == '0) || row_last || col_last;
      tag.frame_end   = row_last && col_last;
   end

   // credit: stage 1 always finds a free slot
   assign req_ready = (CRW'(q_level) + CRW'(s1_valid_ff)) < CRW'(QUEUE_DEPTH);
   assign accept    = req_valid && req_ready;

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (accept) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && frame_start) begin
         act_w_ff <= clamp_w;
         act_h_ff <= clamp_h;
      end
      if (accept) begin
         s1_tag_ff <= tag;
         s1_row_ff <= row_ff;
         s1_col_ff <= col_ff;
         s1_pix_ff <= {req_in_alpha, req_in_blue, req_in_green, req_in_red};
      end
   end

   // read at accept, age the column in the cycle after
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= line_mem[col_ff];
      end
      if (s1_valid_ff) begin
         line_mem[s1_col_ff] <= {rd_data_ff[PIX_W-1:0], s1_pix_ff};
      end
   end

   assign push_valid = s1_valid_ff;
   assign push_data  = {s1_tag_ff, s1_row_ff, s1_col_ff,
                        rd_data_ff[2*PIX_W-1:PIX_W], rd_data_ff[PIX_W-1:0], s1_pix_ff};

`ifndef NO_ASSERTIONS
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (CRW'(q_level) < CRW'(QUEUE_DEPTH)))
      else $error("push into full queue");

   a_counters_in_frame: assert property (@(posedge clock) disable iff (reset)
      ((row_ff != '0) || (col_ff != '0)) |->
         ((WW'(col_ff) < act_w_ff) && (HW'(row_ff) < act_h_ff)))
      else $error("raster counter beyond latched frame size");
`endif

endmodule

// File: hw/rtl/bxf_back.sv
// Back end: 3x3 window, channel sums, divide by nine and result sequencing.
module bxf_back #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_valid,
   input  logic [bxf_pkg::TAG_W + $clog2(MAX_HEIGHT) + $clog2(MAX_WIDTH)
                 + 3*bxf_pkg::PIX_W - 1:0]     q_data,
   output logic                                q_pop,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bxf_pkg::OUT_ROW_W-1:0]       rsp_out_row,
   output logic [bxf_pkg::OUT_COL_W-1:0]       rsp_out_col,
   output logic [bxf_pkg::CH_W-1:0]            rsp_out_red,
   output logic [bxf_pkg::CH_W-1:0]            rsp_out_green,
   output logic [bxf_pkg::CH_W-1:0]            rsp_out_blue,
   output logic [bxf_pkg::CH_W-1:0]            rsp_out_alpha,
   output logic                                rsp_frame_end
);

   import bxf_pkg::*;

   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int CW = $clog2(MAX_WIDTH);

   bxf_tag_type      q_tag;
   logic [RW-1:0]    q_row;
   logic [CW-1:0]    q_col;
   logic [PIX_W-1:0] q_upper, q_middle, q_pix;

   assign {q_tag, q_row, q_col, q_upper, q_middle, q_pix} = q_data;

   // win_ff[column][position], column 2 is newest, position 2 is current row
   logic [PIX_W-1:0] win_ff [3][3];
   logic             w_valid_ff;
   bxf_tag_type      w_tag_ff;
   logic [RW-1:0]    w_row_ff;
   logic [CW-1:0]    w_col_ff;

   logic [SUM_W-1:0] sum_c [4];

   logic             s_valid_ff;
   logic             s_mean_pend_ff, s_border_pend_ff;
   logic             s_fe_ff;
   logic [SUM_W-1:0] s_sum_ff [4];
   logic [RW-1:0]    s_row_ff;
   logic [CW-1:0]    s_col_ff;
   logic [PIX_W-1:0] s_pix_ff;

   logic             rsp_valid_ff;
   logic [OUT_ROW_W-1:0] rsp_row_ff;
   logic [OUT_COL_W-1:0] rsp_col_ff;
   logic [PIX_W-1:0] rsp_pix_ff;
   logic             rsp_fe_ff;

   logic             out_free, emit_mean, emit_border, s_last, s_free, w_move;
   logic [31:0]      mean_row32, mean_col32, brd_row32, brd_col32;

   always_comb begin
      for (int ch = 0; ch < 4; ch++) begin
         sum_c[ch] = '0;
         for (int k = 0; k < 3; k++) begin
            for (int m = 0; m < 3; m++) begin
               sum_c[ch] = sum_c[ch] + SUM_W'(win_ff[k][m][ch*CH_W +: CH_W]);
            end
         end
      end
   end

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign emit_mean   = s_valid_ff && s_mean_pend_ff && out_free;
   assign emit_border = s_valid_ff && !s_mean_pend_ff && s_border_pend_ff && out_free;
   assign s_last      = s_valid_ff && ((!s_mean_pend_ff && !s_border_pend_ff) ||
                                       emit_border || (emit_mean && !s_border_pend_ff));
   assign s_free      = !s_valid_ff || s_last;
   assign w_move      = w_valid_ff && s_free;
   assign q_pop       = q_valid && (!w_valid_ff || w_move);

   assign mean_row32 = 32'(s_row_ff) - 32'd1;
   assign mean_col32 = 32'(s_col_ff) - 32'd1;
   assign brd_row32  = 32'(s_row_ff);
   assign brd_col32  = 32'(s_col_ff);

   // window shifts once per word, in stream order
   always_ff @(posedge clock) begin
      if (q_pop) begin
         for (int m = 0; m < 3; m++) begin
            win_ff[0][m] <= win_ff[1][m];
            win_ff[1][m] <= win_ff[2][m];
         end
         win_ff[2][0] <= q_upper;
         win_ff[2][1] <= q_middle;
         win_ff[2][2] <= q_pix;
         w_tag_ff     <= q_tag;
         w_row_ff     <= q_row;
         w_col_ff     <= q_col;
      end
      if (w_move) begin
         for (int ch = 0; ch < 4; ch++) begin
            s_sum_ff[ch] <= sum_c[ch];
         end
         s_fe_ff  <= w_tag_ff.frame_end;
         s_row_ff <= w_row_ff;
         s_col_ff <= w_col_ff;
         s_pix_ff <= win_ff[2][2];
      end
      if (emit_mean) begin
         rsp_row_ff <= mean_row32[OUT_ROW_W-1:0];
         rsp_col_ff <= mean_col32[OUT_COL_W-1:0];
         rsp_pix_ff <= {bxf_div9(s_sum_ff[3]), bxf_div9(s_sum_ff[2]),
                        bxf_div9(s_sum_ff[1]), bxf_div9(s_sum_ff[0])};
         rsp_fe_ff  <= 1'b0;
      end else if (emit_border) begin
         rsp_row_ff <= brd_row32[OUT_ROW_W-1:0];
         rsp_col_ff <= brd_col32[OUT_COL_W-1:0];
         rsp_pix_ff <= s_pix_ff;
         rsp_fe_ff  <= s_fe_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_valid_ff       <= 1'b0;
         s_valid_ff       <= 1'b0;
         s_mean_pend_ff   <= 1'b0;
         s_border_pend_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (q_pop) begin
            w_valid_ff <= 1'b1;
         end else if (w_move) begin
            w_valid_ff <= 1'b0;
         end

         if (w_move) begin
            s_valid_ff       <= 1'b1;
            s_mean_pend_ff   <= w_tag_ff.need_mean;
            s_border_pend_ff <= w_tag_ff.need_border;
         end else if (s_last) begin
            s_valid_ff       <= 1'b0;
            s_mean_pend_ff   <= 1'b0;
            s_border_pend_ff <= 1'b0;
         end else if (emit_mean) begin
            s_mean_pend_ff <= 1'b0;
         end

         if (emit_mean || emit_border) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_out_red   = rsp_pix_ff[0*CH_W +: CH_W];
   assign rsp_out_green = rsp_pix_ff[1*CH_W +: CH_W];
   assign rsp_out_blue  = rsp_pix_ff[2*CH_W +: CH_W];
   assign rsp_out_alpha = rsp_pix_ff[3*CH_W +: CH_W];
   assign rsp_frame_end = rsp_fe_ff;

`ifndef NO_ASSERTIONS
   a_border_follows_mean: assert property (@(posedge clock) disable iff (reset)
      (emit_mean && s_border_pend_ff) |=> s_valid_ff)
      else $error("border result dropped after mean result");

   a_window_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (w_valid_ff && !s_free) |=>
         (w_valid_ff && $stable(w_row_ff) && $stable(w_col_ff)))
      else $error("window stage changed while stalled");
`endif

endmodule

// File: hw/rtl/box_filter_3x3_rgba.sv
// Path: stage 1, queue, window stage, sum stage, then the registered result.
// Throughput: one word per cycle when not stalled. A word owing two results (right
//   column from row 2, bottom row from column 2) holds the back end for its extra result;
//   the 4-word queue takes up a few of those, after which req_ready drops for each.
// Reset: synchronous, clears counters, queue and valid bits; size registers go to
//   640x480. Line memories are not cleared and need no clearing pass.
module box_filter_3x3_rgba #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   // configuration writes
   input  logic                            csr_wr_en,
   input  bxf_pkg::bxf_csr_type            csr_index,
   input  logic [bxf_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // pixel words in, raster order
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [bxf_pkg::CH_W-1:0]        req_in_red,
   input  logic [bxf_pkg::CH_W-1:0]        req_in_green,
   input  logic [bxf_pkg::CH_W-1:0]        req_in_blue,
   input  logic [bxf_pkg::CH_W-1:0]        req_in_alpha,
   // filtered or passed-through pixel words out
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [bxf_pkg::OUT_ROW_W-1:0]   rsp_out_row,
   output logic [bxf_pkg::OUT_COL_W-1:0]   rsp_out_col,
   output logic [bxf_pkg::CH_W-1:0]        rsp_out_red,
   output logic [bxf_pkg::CH_W-1:0]        rsp_out_green,
   output logic [bxf_pkg::CH_W-1:0]        rsp_out_blue,
   output logic [bxf_pkg::CH_W-1:0]        rsp_out_alpha,
   output logic                            rsp_frame_end
);

   import bxf_pkg::*;

   // queue word: {tag, row, col, row r-2 pixel, row r-1 pixel, current pixel}
   localparam int ENTRY_W = TAG_W + $clog2(MAX_HEIGHT) + $clog2(MAX_WIDTH) + 3*PIX_W;

   logic                     push_valid;
   logic [ENTRY_W-1:0]       push_data;
   logic                     q_valid;
   logic [ENTRY_W-1:0]       q_data;
   logic                     q_pop;
   logic [QUEUE_LEVEL_W-1:0] q_level;

   // Front end: counts the raster position, latches the frame size at the
   // first word of each frame, reads the two stored rows for this column and
   // tags the word with the results it owes. The line memory column is
   // rewritten in the cycle after its read.
   bxf_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_red   (req_in_red),
      .req_in_green (req_in_green),
      .req_in_blue  (req_in_blue),
      .req_in_alpha (req_in_alpha),
      .q_level      (q_level),
      .push_valid   (push_valid),
      .push_data    (push_data)
   );

   // Decouples the stream side from the result side. The front end holds a
   // credit for its in-flight word, so a push never meets a full queue.
   bxf_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (q_pop),
      .out_valid  (q_valid),
      .out_data   (q_data),
      .level      (q_level)
   );

   // Back end: shifts the 3x3 window, sums each channel, divides by nine
   // with a reciprocal multiply, then emits the smoothed word for the pixel
   // up-left of the current one before the border word of the current one.
   bxf_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_data        (q_data),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_out_alpha (rsp_out_alpha),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the 3x3 RGBA box filter: random frames, sizes and stalls.
module tb;
   import bxf_pkg::*;

   localparam int MAX_W     = 2048;
   localparam int MAX_H     = 4096;
   localparam int BOX_TAPS  = 9;         // samples per channel in one window
   localparam int SETTLE    = 16;        // cycles past the last result before a CSR write
   localparam int LIMIT     = 1_500_000; // cycle budget for the whole run
   localparam int RAND_WORDS = 1600;

   // one pixel word in, red in the low byte as on the line memories
   typedef struct packed {
      logic [CH_W-1:0] alpha;
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] red;
   } px_in_type;

   // one result word, same field order as the rsp_ ports
   typedef struct packed {
      logic [OUT_ROW_W-1:0] row;
      logic [OUT_COL_W-1:0] col;
      logic [CH_W-1:0]      red;
      logic [CH_W-1:0]      green;
      logic [CH_W-1:0]      blue;
      logic [CH_W-1:0]      alpha;
      logic                 last;
   } filt_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_wr_en = 1'b0;
   bxf_csr_type           csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic            req_valid    = 1'b0;
   logic            req_ready;
   logic [CH_W-1:0] req_in_red   = '0;
   logic [CH_W-1:0] req_in_green = '0;
   logic [CH_W-1:0] req_in_blue  = '0;
   logic [CH_W-1:0] req_in_alpha = '0;

   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [OUT_ROW_W-1:0] rsp_out_row;
   logic [OUT_COL_W-1:0] rsp_out_col;
   logic [CH_W-1:0]      rsp_out_red;
   logic [CH_W-1:0]      rsp_out_green;
   logic [CH_W-1:0]      rsp_out_blue;
   logic [CH_W-1:0]      rsp_out_alpha;
   logic                 rsp_frame_end;

   box_filter_3x3_rgba #(
      .MAX_WIDTH (MAX_W),
      .MAX_HEIGHT(MAX_H)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_red   (req_in_red),
      .req_in_green (req_in_green),
      .req_in_blue  (req_in_blue),
      .req_in_alpha (req_in_alpha),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_row  (rsp_out_row),
      .rsp_out_col  (rsp_out_col),
      .rsp_out_red  (rsp_out_red),
      .rsp_out_green(rsp_out_green),
      .rsp_out_blue (rsp_out_blue),
      .rsp_out_alpha(rsp_out_alpha),
      .rsp_frame_end(rsp_frame_end)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Filter predictor: own copy of line memories, window and counters.
   // ------------------------------------------------------------------
   logic [PIX_W-1:0] line_m2 [MAX_W];   // row r-2
   logic [PIX_W-1:0] line_m1 [MAX_W];   // row r-1
   logic [PIX_W-1:0] win     [9];       // 0..2 top row, 6..8 current row
   int cur_row, cur_col;
   int used_w, used_h;                  // size latched at frame start
   int reg_w = WIDTH_RESET;             // CSR contents as last written
   int reg_h = HEIGHT_RESET;

   filt_word_type filtered_q [$];       // results still owed by the block
   px_in_type     pixel_feed [$];       // words waiting to be offered

   int words_queued, words_taken;
   int results_seen, frames_done, faults;
   int send_odds, take_odds;            // 0: no idling, else 1-in-N chance of a burst

   // zero acts as 1, oversize clamps to the memory size
   function automatic int fit_dim(input int v, input int maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic filt_word_type make_word(input int row, input int col,
                                               input logic [PIX_W-1:0] pix,
                                               input logic last);
      filt_word_type w;
      w.row   = OUT_ROW_W'(row);
      w.col   = OUT_COL_W'(col);
      w.red   = pix[0 +: CH_W];
      w.green = pix[CH_W +: CH_W];
      w.blue  = pix[2*CH_W +: CH_W];
      w.alpha = pix[3*CH_W +: CH_W];
      w.last  = last;
      return w;
   endfunction

   task automatic predict_filter(input px_in_type px);
      logic [PIX_W-1:0] upper, middle, mean;
      int sum;
      logic border, last;
      if (cur_row == 0 && cur_col == 0) begin
         used_w = fit_dim(reg_w, MAX_W);
         used_h = fit_dim(reg_h, MAX_H);
      end
      upper  = line_m2[cur_col];
      middle = line_m1[cur_col];
      line_m2[cur_col] = middle;
      line_m1[cur_col] = px;

      // window slides left, new right column is the column just read
      for (int i = 0; i < 9; i++)
         if (i % 3 != 2) win[i] = win[i+1];
      win[2] = upper;
      win[5] = middle;
      win[8] = px;

      for (int ch = 0; ch < 4; ch++) begin
         sum = 0;
         for (int i = 0; i < 9; i++) sum += win[i][CH_W*ch +: CH_W];
         mean[CH_W*ch +: CH_W] = CH_W'(sum / BOX_TAPS);
      end

      // interior result for the pixel up and left comes first
      if (cur_row >= 2 && cur_col >= 2)
         filtered_q.push_back(make_word(cur_row - 1, cur_col - 1, mean, 1'b0));

      border = (cur_row == 0) || (cur_col == 0) ||
               (cur_row + 1 == used_h) || (cur_col + 1 == used_w);
      last   = (cur_row + 1 == used_h) && (cur_col + 1 == used_w);
      if (border) filtered_q.push_back(make_word(cur_row, cur_col, px, last));

      cur_col++;
      if (cur_col >= used_w) begin
         cur_col = 0;
         cur_row++;
         if (cur_row >= used_h) cur_row = 0;
      end
   endtask

   initial begin
      for (int i = 0; i < MAX_W; i++) begin
         line_m2[i] = '0;
         line_m1[i] = '0;
      end
      for (int i = 0; i < 9; i++) win[i] = '0;
      cur_row = 0;
      cur_col = 0;
      used_w  = fit_dim(reg_w, MAX_W);
      used_h  = fit_dim(reg_h, MAX_H);
   end

   // ------------------------------------------------------------------
   // Driver: offers queued words, predicts each one as it is accepted.
   // Valid holds until accepted; gaps only start on a free slot.
   // ------------------------------------------------------------------
   int        send_gap;
   px_in_type feed_word;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_filter({req_in_alpha, req_in_blue, req_in_green, req_in_red});
            words_taken++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (send_odds != 0 && $urandom_range(1, send_odds) == 1) begin
               send_gap  <= $urandom_range(0, 8);   // start a random-length idle burst
               req_valid <= 1'b0;
            end else if (pixel_feed.size() != 0) begin
               feed_word     = pixel_feed.pop_front();
               req_in_red   <= feed_word.red;
               req_in_green <= feed_word.green;
               req_in_blue  <= feed_word.blue;
               req_in_alpha <= feed_word.alpha;
               req_valid    <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: random back-pressure, compares each accepted result word
   // against the oldest prediction.
   // ------------------------------------------------------------------
   int            take_gap;
   filt_word_type got_word, want_word;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         take_gap  <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got_word = {rsp_out_row, rsp_out_col, rsp_out_red, rsp_out_green,
                        rsp_out_blue, rsp_out_alpha, rsp_frame_end};
            if (filtered_q.size() == 0) begin
               $display("%0t unexpected result: row %0d col %0d rgba %h %h %h %h end %b",
                        $time, got_word.row, got_word.col, got_word.red, got_word.green,
                        got_word.blue, got_word.alpha, got_word.last);
               faults++;
            end else begin
               want_word = filtered_q.pop_front();
               if (got_word !== want_word) begin
                  $display("%0t mismatch: expected row %0d col %0d rgba %h %h %h %h end %b",
                           $time, want_word.row, want_word.col, want_word.red,
                           want_word.green, want_word.blue, want_word.alpha, want_word.last);
                  $display("%0t            actual row %0d col %0d rgba %h %h %h %h end %b",
                           $time, got_word.row, got_word.col, got_word.red, got_word.green,
                           got_word.blue, got_word.alpha, got_word.last);
                  faults++;
               end
               if (want_word.last) frames_done++;
               results_seen++;
            end
         end
         if (take_gap != 0) begin
            take_gap  <= take_gap - 1;
            rsp_ready <= 1'b0;
         end else if (take_odds != 0 && $urandom_range(1, take_odds) == 1) begin
            take_gap  <= $urandom_range(0, 8);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // hang guard
   int cycle_count;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("timeout after %0d cycles, %0d results still owed",
                  cycle_count, filtered_q.size());
         $display("box_filter_3x3_rgba regression: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus sequencing
   // ------------------------------------------------------------------

   // every queued word accepted and every owed result taken
   task automatic drain_words();
      @(posedge clock);
      while (words_taken != words_queued || filtered_q.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input bxf_csr_type idx, input int value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      if (idx == CSR_IMAGE_WIDTH) reg_w = value & 'hFFF;
      else reg_h = value & 'h1FFF;
   endtask

   // sizes are only touched with the block idle; words with no result
   // may still be in the pipe, hence the settle time
   task automatic set_frame_size(input int w, input int h);
      drain_words();
      repeat (SETTLE) @(posedge clock);
      csr_write(CSR_IMAGE_WIDTH, w);
      csr_write(CSR_IMAGE_HEIGHT, h);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // words still needed to close the frame in progress (latched size)
   function automatic int frame_pixels_left();
      if (cur_row == 0 && cur_col == 0) return 0;
      return used_w * used_h - (cur_row * used_w + cur_col);
   endfunction

   task automatic push_pixel(input px_in_type px);
      pixel_feed.push_back(px);
      words_queued++;
   endtask

   function automatic px_in_type random_pixel();
      px_in_type p;
      case ($urandom_range(0, 7))
         0: begin
            // saturated channels: sums hit 0 and 2295
            p.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            p.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            p.alpha = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         end
         1: begin
            p.red   = CH_W'($urandom_range(240, 255));
            p.green = CH_W'($urandom_range(240, 255));
            p.blue  = CH_W'($urandom_range(240, 255));
            p.alpha = CH_W'($urandom_range(240, 255));
         end
         default: p = $urandom();
      endcase
      return p;
   endfunction

   task automatic queue_pixels(input int n);
      for (int i = 0; i < n; i++) push_pixel(random_pixel());
   endtask

   // finish the open frame, then whole frames at the new size, then maybe
   // a partial one so the next size write lands mid-frame
   task automatic run_frames(input int w, input int h, input int frames,
                             input int partial, output int sent);
      set_frame_size(w, h);
      sent = frame_pixels_left() + frames * fit_dim(w, MAX_W) * fit_dim(h, MAX_H) + partial;
      queue_pixels(sent);
   endtask

   int random_words, n, w, h, fw, fh, pick;

   initial begin
      send_odds = 0;
      take_odds = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: 3x3 frame of all-ones, window sum at its maximum
      set_frame_size(3, 3);
      for (int i = 0; i < 9; i++) push_pixel('1);

      // 3x3 with distinct channels per pixel, one interior mean
      set_frame_size(3, 3);
      for (int i = 0; i < 9; i++)
         push_pixel({8'(8'h80 ^ i), (i % 2 == 1) ? 8'hFF : 8'h00,
                     8'(255 - 31 * i), 8'(31 * i)});

      // zero width and height act as a single-pixel frame
      set_frame_size(0, 0);
      push_pixel(32'hA5_5A_00_FF);

      // below 3 in both axes: everything passes through
      set_frame_size(2, 2);
      push_pixel('0);
      push_pixel(32'h55_AA_55_AA);
      push_pixel(32'hAA_55_AA_55);
      push_pixel('1);

      // random part: mostly small frames, changing stall mix per phase
      random_words = 0;
      while (random_words < RAND_WORDS) begin
         pick = $urandom_range(0, 9);
         w = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         pick = $urandom_range(0, 9);
         h = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(11, 20) : $urandom_range(1, 10);
         fw = fit_dim(w, MAX_W);
         fh = fit_dim(h, MAX_H);
         send_odds = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(3, 12);
         take_odds = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(3, 12);
         run_frames(w, h, $urandom_range(1, 2),
                    $urandom_range(0, 1) ? $urandom_range(0, fw * fh - 1) : 0, n);
         random_words += n;
      end

      // closing stretch at full rate, no idling either side; it ends in the
      // top row of a frame whose size registers are both above the maximum
      send_odds = 0;
      take_odds = 0;
      run_frames(5, 4, 2, 0, n);
      run_frames(4095, 8191, 0, 48, n);

      drain_words();
      repeat (SETTLE) @(posedge clock);
      if (filtered_q.size() != 0) faults++;

      $display("covered %0d pixel words, %0d result words, %0d frames closed",
               words_taken, results_seen, frames_done);
      $display("sizes from 1x1 to 40x20 under stalls, oversize registers at the end, %0d errors",
               faults);
      if (faults == 0) begin
         $display("box_filter_3x3_rgba regression: pass");
      end else begin
         $display("box_filter_3x3_rgba regression: fail");
      end
      $finish;
   end

endmodule
